// ===== rtl/cdn_pkg.sv =====
// Shared constants and helper functions for the calendar date to day number block.
// Holds field widths, stream packing, and the calendar and fraction constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdn_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int SECS_W = 27;
    localparam int DNUM_W = 23;
    localparam int FRAC_W = 32;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    localparam int DIV100_SHIFT = 19;
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam logic [6:0]  HUNDRED    = 7'd100;

    localparam logic [17:0] CYCLE_DAYS = 18'd146097;
    localparam logic [10:0] QUAD_DAYS  = 11'd1461;
    localparam logic [19:0] DAY_BIAS   = 20'd824979;

    localparam logic [SECS_W-1:0] DAY_TICKS = 27'd88473600;
    localparam logic [9:0]        FRAC_DIV  = 10'd675;
    localparam logic [32:0]       FRAC_RECIP = 33'((64'd1 << 42) / 64'd675);

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_MAR = 4'd3;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (mon) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the start of a month, months counted from March
    function automatic logic [8:0] march_days(input logic [MON_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_date_to_day_number.sv =====
// Top level: Gregorian date and time of day to modified Julian day and day fraction.
// Five-stage pipeline, one transaction per cycle unless stalled. Depends on cdn_pkg.
//
// Usage:
//   Slave stream carries one date per transaction; master stream carries one result.
//   Throughput is one transaction per cycle with no bubbles unless the output
//   register holds a result that the receiver has not yet taken.
//   All stages advance together; the last stage is the output register. When the
//   receiver holds i_m_axis_tready low with a result pending, the whole pipeline
//   freezes and o_s_axis_tready drops, so nothing is lost or repeated. Empty
//   stages do not fill while the output waits.
//   An invalid month or day yields tuser = 0 with day number and fraction zero.
//   A time of one full day or more saturates the fraction to all ones.
//   Synchronous reset clears all stage valid bits; payload registers are not reset.
//   Pipeline: divide by 100 product and fraction partial products, quotient and
//   reciprocal sum, remainder, leap check and fraction back-multiply, calendar
//   terms and fraction correction, final sum into the output register.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_to_day_number
    import cdn_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // day_of_month[4:0], month_of_year[8:5], year_full[22:9], seconds_of_day[49:23]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // day_number[22:0], day_fraction[54:23]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // date_valid[0]
    output logic                        o_m_axis_tuser
);

    logic       en;
    logic [4:0] r_vld;

    logic [DAY_W-1:0]  in_day;
    logic [MON_W-1:0]  in_mon;
    logic [YEAR_W-1:0] in_year;
    logic [SECS_W-1:0] in_secs;

    // stage 1
    logic [DAY_W-1:0]  r1_day;
    logic [MON_W-1:0]  r1_mon;
    logic [YEAR_W-1:0] r1_year;
    logic [26:0]       r1_qprod;
    logic [SECS_W-1:0] r1_secs;
    logic              r1_sat;
    logic [42:0]       r1_pp_hi;
    logic [43:0]       r1_pp_lo;
    logic [26:0]       n1_qprod;
    logic [42:0]       n1_pp_hi;
    logic [43:0]       n1_pp_lo;

    // stage 2
    logic [DAY_W-1:0]  r2_day;
    logic [MON_W-1:0]  r2_mon;
    logic [YEAR_W-1:0] r2_year;
    logic [7:0]        r2_q;
    logic [SECS_W-1:0] r2_secs;
    logic              r2_sat;
    logic [31:0]       r2_rp;
    logic [59:0]       n2_sum;

    // stage 3
    logic [DAY_W-1:0]  r3_day;
    logic [MON_W-1:0]  r3_mmar;
    logic              r3_ok;
    logic [7:0]        r3_cent;
    logic [6:0]        r3_yy;
    logic [SECS_W-1:0] r3_secs;
    logic              r3_sat;
    logic [31:0]       r3_rp;
    logic [41:0]       r3_prod;
    logic [14:0]       n3_hund;
    logic [14:0]       n3_rem_full;
    logic [6:0]        n3_rem;
    logic              n3_leap;
    logic              n3_early;
    logic              n3_ok;
    logic [7:0]        n3_cent;
    logic [6:0]        n3_yy;
    logic [MON_W-1:0]  n3_mmar;
    logic [41:0]       n3_prod;

    // stage 4
    logic [DAY_W-1:0]  r4_day;
    logic              r4_ok;
    logic [23:0]       r4_cterm;
    logic [15:0]       r4_yterm;
    logic [8:0]        r4_mterm;
    logic [FRAC_W-1:0] r4_frac;
    logic [25:0]       n4_cprod;
    logic [17:0]       n4_yprod;
    logic [41:0]       n4_diff;
    logic [FRAC_W-1:0] n4_frac;

    // stage 5 / output
    logic              r5_ok;
    logic [DNUM_W-1:0] r5_dnum;
    logic [FRAC_W-1:0] r5_frac;
    logic [24:0]       n5_sum;

    assign en              = !r_vld[4] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[4];
    assign o_m_axis_tuser  = r5_ok;
    assign o_m_axis_tdata  = {1'b0, r5_frac, r5_dnum};

    assign in_day  = i_s_axis_tdata[4:0];
    assign in_mon  = i_s_axis_tdata[8:5];
    assign in_year = i_s_axis_tdata[22:9];
    assign in_secs = i_s_axis_tdata[49:23];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[3:0], i_s_axis_tvalid};
        end
    end

    // stage 1: reciprocal products
    always_comb begin
        n1_qprod = 27'(in_year) * 27'(DIV100_MUL);
        n1_pp_hi = 43'(in_secs) * 43'(FRAC_RECIP[32:17]);
        n1_pp_lo = 44'(in_secs) * 44'(FRAC_RECIP[16:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_day   <= in_day;
            r1_mon   <= in_mon;
            r1_year  <= in_year;
            r1_qprod <= n1_qprod;
            r1_secs  <= in_secs;
            r1_sat   <= in_secs >= DAY_TICKS;
            r1_pp_hi <= n1_pp_hi;
            r1_pp_lo <= n1_pp_lo;
        end
    end

    // stage 2: century quotient, fraction estimate
    assign n2_sum = {r1_pp_hi, 17'd0} + 60'(r1_pp_lo);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_day  <= r1_day;
            r2_mon  <= r1_mon;
            r2_year <= r1_year;
            r2_q    <= r1_qprod[DIV100_SHIFT+7:DIV100_SHIFT];
            r2_secs <= r1_secs;
            r2_sat  <= r1_sat;
            r2_rp   <= n2_sum[58:27];
        end
    end

    // stage 3: remainder, leap year, date check, March-based year split
    always_comb begin
        n3_hund     = 15'(r2_q) * 15'(HUNDRED);
        n3_rem_full = 15'(r2_year) - n3_hund;
        n3_rem      = n3_rem_full[6:0];
        n3_leap     = (r2_year[1:0] == 2'd0 && n3_rem != 7'd0)
                   || (n3_rem == 7'd0 && r2_q[1:0] == 2'd0);
        n3_ok       = r2_mon >= MON_JAN && r2_mon <= MON_DEC && r2_day != 5'd0
                   && r2_day <= month_len(r2_mon, n3_leap);
        n3_early    = r2_mon < MON_MAR;
        if (!n3_early) begin
            n3_mmar = r2_mon - MON_MAR;
            n3_cent = r2_q + 8'd4;
            n3_yy   = n3_rem;
        end else if (n3_rem != 7'd0) begin
            n3_mmar = r2_mon + 4'd9;
            n3_cent = r2_q + 8'd4;
            n3_yy   = n3_rem - 7'd1;
        end else begin
            n3_mmar = r2_mon + 4'd9;
            n3_cent = r2_q + 8'd3;
            n3_yy   = 7'd99;
        end
        n3_prod = 42'(r2_rp) * 42'(FRAC_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_day  <= r2_day;
            r3_mmar <= n3_mmar;
            r3_ok   <= n3_ok;
            r3_cent <= n3_cent;
            r3_yy   <= n3_yy;
            r3_secs <= r2_secs;
            r3_sat  <= r2_sat;
            r3_rp   <= r2_rp;
            r3_prod <= n3_prod;
        end
    end

    // stage 4: calendar terms, fraction correction
    always_comb begin
        n4_cprod = 26'(r3_cent) * 26'(CYCLE_DAYS);
        n4_yprod = 18'(r3_yy) * 18'(QUAD_DAYS);
        n4_diff  = {r3_secs, 15'd0} - r3_prod;
        if (r3_sat) begin
            n4_frac = '1;
        end else begin
            n4_frac = r3_rp + 32'(n4_diff >= 42'(FRAC_DIV));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_day   <= r3_day;
            r4_ok    <= r3_ok;
            r4_cterm <= n4_cprod[25:2];
            r4_yterm <= n4_yprod[17:2];
            r4_mterm <= march_days(r3_mmar);
            r4_frac  <= n4_frac;
        end
    end

    // stage 5: day number sum, zero on an invalid date
    assign n5_sum = 25'(r4_cterm) + 25'(r4_yterm) + 25'(r4_mterm) + 25'(r4_day)
                  - 25'(DAY_BIAS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ok   <= r4_ok;
            r5_dnum <= r4_ok ? n5_sum[DNUM_W-1:0] : '0;
            r5_frac <= r4_ok ? r4_frac : '0;
        end
    end

endmodule

`default_nettype wire
